@@ hw/rtl/hash_group_id_assigner_defines.svh @@
`ifndef HASH_GROUP_ID_ASSIGNER_DEFINES_SVH
`define HASH_GROUP_ID_ASSIGNER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define HGIA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define HGIA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/hgia_pkg.sv @@
`timescale 1ns / 1ps
package hgia_pkg;

    localparam int KEY_W     = 64;
    localparam int OLD_W     = 12;
    localparam int GID_W     = 12;
    localparam int FIRST_W   = 33;
    localparam int COUNT_W   = 13;
    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = 32;
    localparam int S_DATA_W  = 80;
    localparam int M_DATA_W  = 64;

    localparam logic [KEY_W-1:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

    localparam logic [CFG_AW-1:0] CFG_ORDER_MODE     = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_USE_OLD_GROUPS = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_POSITION_BASE  = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_LINK,
        S_ENT,
        S_GRP,
        S_UPD,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        H_IDLE,
        H_MUL,
        H_MIX,
        H_PROD,
        H_SUM,
        H_REM,
        H_FIX
    } t_hash_state;

endpackage

@@ hw/rtl/hash_group_id_assigner.sv @@
`timescale 1ns / 1ps
// channel   dir  handshake                  payload
// s (in)    in   i_s_tvalid / o_s_tready    tdata key, old_group; tlast end_of_column
// m (out)   out  o_m_tvalid / i_m_tready    tdata group_id .. overflow; tlast end_out
// cfg       in   i_cfg_we                   i_cfg_addr, i_cfg_wdata
//
// Consecutive mode: an item is matched against the previous one, then its group is read and
// updated. Hash mode: the key is hashed, then the bucket head and each chain entry visited are
// read; the first item of a column skips them. A bucket count that is not a power of two adds
// remainder steps to the hash. A dropped item goes straight to the output. After reset and after
// each end-of-column item the bucket-head memory is swept, with the input held off. A stalled
// output holds one result while the next item is taken.
module hash_group_id_assigner import hgia_pkg::*; #(
    parameter int MAX_ITEMS    = 4096,
    parameter int HASH_BUCKETS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [63:0] key, [75:64] old_group, [79:76] zero
    input  logic [S_DATA_W-1:0]  i_s_tdata,
    input  logic                 i_s_tlast,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [11:0] group_id, [12] is_new, [45:13] first_position, [58:46] group_count,
    // [59] overflow, [63:60] zero
    output logic [M_DATA_W-1:0]  o_m_tdata,
    output logic                 o_m_tlast,
    input  logic                 i_cfg_we,
    input  logic [CFG_AW-1:0]    i_cfg_addr,
    input  logic [CFG_DW-1:0]    i_cfg_wdata
);

    localparam int PW = $clog2(MAX_ITEMS);
    localparam int LW = $clog2(MAX_ITEMS + 1);
    localparam int BW = $clog2(HASH_BUCKETS);
    localparam int EW = LW + KEY_W + OLD_W + PW;
    localparam int GW = LW + PW;

    t_state r_state, n_state;

    logic                r_order_mode, r_use_old;
    logic [CFG_DW-1:0]   r_base;

    logic [LW-1:0]       r_idx, r_next_group;
    logic [KEY_W-1:0]    r_prev_key;
    logic [OLD_W-1:0]    r_prev_old;
    logic [PW-1:0]       r_prev_gid;
    logic [BW-1:0]       r_clr_addr;

    logic [KEY_W-1:0]    r_key;
    logic [OLD_W-1:0]    r_old;
    logic                r_end, r_ovf, r_found;
    logic [PW-1:0]       r_gid;
    logic [BW-1:0]       r_bkt;
    logic [LW-1:0]       r_head;

    logic [PW-1:0]       r_res_gid;
    logic [PW-1:0]       r_res_first;
    logic [LW-1:0]       r_res_count;

    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;
    logic                r_out_last;

    logic [LW-1:0]       head_mem [HASH_BUCKETS];
    logic [EW-1:0]       ent_mem  [MAX_ITEMS];
    logic [GW-1:0]       grp_mem  [MAX_ITEMS];

    logic [LW-1:0]       r_head_rdata;
    logic [EW-1:0]       r_ent_rdata;
    logic [GW-1:0]       r_grp_rdata;

    logic                head_we, head_re, ent_we, ent_re, grp_we, grp_re;
    logic [BW-1:0]       head_waddr;
    logic [LW-1:0]       head_wdata;
    logic [PW-1:0]       ent_raddr, grp_waddr;
    logic [EW-1:0]       ent_wdata;
    logic [GW-1:0]       grp_wdata;

    logic                s_accept, out_load, hash_start, hash_done, is_full, prev_match;
    logic [BW-1:0]       hash_bucket;
    logic [PW-1:0]       pos, gid_upd, first_upd;
    logic [LW-1:0]       count_upd;

    logic [LW-1:0]       ent_link;
    logic [KEY_W-1:0]    ent_key;
    logic [OLD_W-1:0]    ent_old;
    logic [PW-1:0]       ent_gid;
    logic                ent_match;

    logic [LW-1:0]       grp_count;
    logic [PW-1:0]       grp_first;

    assign {ent_link, ent_key, ent_old, ent_gid} = r_ent_rdata;
    assign {grp_count, grp_first}                = r_grp_rdata;

    assign pos        = r_idx[PW-1:0];
    assign is_full    = (r_idx == LW'(MAX_ITEMS));
    assign ent_match  = (ent_key == r_key) && (!r_use_old || ent_old == r_old);
    assign prev_match = (i_s_tdata[KEY_W-1:0] == r_prev_key) &&
                        (!r_use_old || i_s_tdata[KEY_W +: OLD_W] == r_prev_old);

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_m_tready);
    assign hash_start = s_accept && !is_full && r_order_mode;

    assign gid_upd    = r_found ? r_gid : r_next_group[PW-1:0];
    assign count_upd  = r_found ? grp_count + 1'b1 : LW'(1);
    assign first_upd  = r_found ? grp_first : pos;

    hgia_hash #(
        .HASH_BUCKETS (HASH_BUCKETS)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (hash_start),
        .i_key    (i_s_tdata[KEY_W-1:0]),
        .o_done   (hash_done),
        .o_bucket (hash_bucket)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_addr == BW'(HASH_BUCKETS - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (s_accept) begin
                    if (is_full) begin
                        n_state = S_DONE;
                    end else if (r_order_mode) begin
                        n_state = S_HASH;
                    end else begin
                        n_state = S_GRP;
                    end
                end
            end
            S_HASH: if (hash_done) n_state = (r_idx == '0) ? S_GRP : S_HEAD;
            S_HEAD: n_state = S_LINK;
            S_LINK: n_state = (r_head_rdata == '0) ? S_GRP : S_ENT;
            S_ENT:  if (ent_match || ent_link == '0) n_state = S_GRP;
            S_GRP:  n_state = S_UPD;
            S_UPD:  n_state = S_DONE;
            S_DONE: if (out_load) n_state = r_end ? S_CLEAR : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        head_we    = 1'b0;
        head_re    = 1'b0;
        head_waddr = r_bkt;
        head_wdata = r_idx + 1'b1;
        ent_we     = 1'b0;
        ent_re     = 1'b0;
        ent_raddr  = PW'(ent_link - 1'b1);
        ent_wdata  = {r_head, r_key, r_old, gid_upd};
        grp_we     = 1'b0;
        grp_re     = 1'b0;
        grp_waddr  = gid_upd;
        grp_wdata  = {count_upd, first_upd};
        unique case (r_state)
            S_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = r_clr_addr;
                head_wdata = '0;
            end
            S_HEAD: head_re = 1'b1;
            S_LINK: begin
                ent_re    = (r_head_rdata != '0);
                ent_raddr = PW'(r_head_rdata - 1'b1);
            end
            S_ENT:  ent_re = !ent_match && (ent_link != '0);
            S_GRP:  grp_re = 1'b1;
            S_UPD: begin
                ent_we  = 1'b1;
                grp_we  = 1'b1;
                head_we = !r_found && r_order_mode;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (head_we) head_mem[head_waddr] <= head_wdata;
        if (head_re) r_head_rdata <= head_mem[r_bkt];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) ent_mem[pos] <= ent_wdata;
        if (ent_re) r_ent_rdata <= ent_mem[ent_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (grp_we) grp_mem[grp_waddr] <= grp_wdata;
        if (grp_re) r_grp_rdata <= grp_mem[r_gid];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_order_mode <= 1'b1;
            r_use_old    <= 1'b0;
            r_base       <= '0;
            r_idx        <= '0;
            r_next_group <= '0;
            r_prev_key   <= '0;
            r_prev_old   <= '0;
            r_prev_gid   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_ORDER_MODE:     r_order_mode <= i_cfg_wdata[0];
                    CFG_USE_OLD_GROUPS: r_use_old    <= i_cfg_wdata[0];
                    CFG_POSITION_BASE:  r_base       <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == S_UPD) begin
                r_idx      <= r_idx + 1'b1;
                r_prev_key <= r_key;
                r_prev_old <= r_old;
                r_prev_gid <= gid_upd;
                if (!r_found) r_next_group <= r_next_group + 1'b1;
            end
            // end of column: drop all column state
            if (out_load && r_end) begin
                r_clr_addr   <= '0;
                r_idx        <= '0;
                r_next_group <= '0;
                r_prev_key   <= '0;
                r_prev_old   <= '0;
                r_prev_gid   <= '0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_key   <= i_s_tdata[KEY_W-1:0];
            r_old   <= i_s_tdata[KEY_W +: OLD_W];
            r_end   <= i_s_tlast;
            r_ovf   <= is_full;
            r_head  <= '0;
            r_found <= !r_order_mode && (r_idx != '0) && prev_match;
            r_gid   <= r_prev_gid;
        end
        if (r_state == S_HASH && hash_done) begin
            r_bkt <= hash_bucket;
        end
        if (r_state == S_LINK) begin
            r_head <= r_head_rdata;
        end
        if (r_state == S_ENT && ent_match) begin
            r_found <= 1'b1;
            r_gid   <= ent_gid;
        end
        if (r_state == S_UPD) begin
            r_res_gid   <= gid_upd;
            r_res_first <= first_upd;
            r_res_count <= count_upd;
        end
        if (out_load) begin
            r_out_last <= r_end;
            if (r_ovf) begin
                r_out_data <= {4'b0, 1'b1, {(M_DATA_W - 5){1'b0}}};
            end else begin
                r_out_data <= {4'b0, 1'b0, COUNT_W'(r_res_count),
                               FIRST_W'(r_base) + FIRST_W'(r_res_first),
                               !r_found, GID_W'(r_res_gid)};
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

@@ hw/rtl/hgia_hash.sv @@
`timescale 1ns / 1ps
module hgia_hash import hgia_pkg::*; #(
    parameter int HASH_BUCKETS = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [KEY_W-1:0]                i_key,
    output logic                            o_done,
    output logic [$clog2(HASH_BUCKETS)-1:0] o_bucket
);

    localparam int          BW        = $clog2(HASH_BUCKETS);
    localparam int          HS_W      = 48;
    localparam bit          IS_POW2   = (HASH_BUCKETS & (HASH_BUCKETS - 1)) == 0;
    // reciprocal of the bucket count, scaled by 2^(HS_W + BW)
    localparam logic [69:0] RECIP_ONE = 70'd1 << (HS_W + BW);
    localparam logic [48:0] RECIP     = 49'(RECIP_ONE / 70'(HASH_BUCKETS));
    localparam logic [BW:0] NB        = (BW+1)'(HASH_BUCKETS);

    t_hash_state        r_state, n_state;
    logic [KEY_W-1:0]   r_key;
    logic [63:0]        r_p0;
    logic [31:0]        r_p1, r_p2;
    logic [HS_W-1:0]    r_hs;
    logic [48:0]        r_q00, r_q10;
    logic [47:0]        r_q01, r_q11;
    logic [BW:0]        r_qlo;
    logic [BW:0]        r_rem;
    logic [BW-1:0]      r_bkt;
    logic               r_done;

    logic [63:0]        w_h, w_hm;
    logic [96:0]        w_prod;
    logic               w_complete;

    assign w_h  = r_p0 + {r_p1 + r_p2, 32'b0};
    assign w_hm = w_h ^ (w_h >> 29);

    // the estimated quotient is low by at most one: one conditional subtract finishes
    assign w_prod = {r_q11, 49'b0} + 97'({r_q10, 24'b0}) + 97'({r_q01, 25'b0})
                  + 97'(r_q00);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            H_IDLE: if (i_start) n_state = H_MUL;
            H_MUL:  n_state = H_MIX;
            H_MIX:  n_state = IS_POW2 ? H_IDLE : H_PROD;
            H_PROD: n_state = H_SUM;
            H_SUM:  n_state = H_REM;
            H_REM:  n_state = H_FIX;
            H_FIX:  n_state = H_IDLE;
            default: n_state = H_IDLE;
        endcase
    end

    always_comb begin
        w_complete = 1'b0;
        unique case (r_state)
            H_MIX:   w_complete = IS_POW2;
            H_FIX:   w_complete = 1'b1;
            default: w_complete = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_complete;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == H_IDLE && i_start) begin
            r_key <= i_key;
        end
        if (r_state == H_MUL) begin
            r_p0 <= r_key[31:0] * HASH_MULT[31:0];
            r_p1 <= 32'(r_key[31:0] * HASH_MULT[63:32]);
            r_p2 <= 32'(r_key[63:32] * HASH_MULT[31:0]);
        end
        if (r_state == H_MIX) begin
            r_hs  <= w_hm[63:16];
            r_bkt <= w_hm[16 +: BW];
        end
        if (r_state == H_PROD) begin
            r_q00 <= r_hs[23:0] * RECIP[24:0];
            r_q01 <= r_hs[23:0] * RECIP[48:25];
            r_q10 <= r_hs[47:24] * RECIP[24:0];
            r_q11 <= r_hs[47:24] * RECIP[48:25];
        end
        if (r_state == H_SUM) begin
            r_qlo <= w_prod[HS_W + BW +: BW + 1];
        end
        // only the low bits matter: the remainder stays below twice the bucket count
        if (r_state == H_REM) begin
            r_rem <= r_hs[BW:0] - (BW+1)'(r_qlo * NB);
        end
        if (r_state == H_FIX) begin
            r_bkt <= (r_rem >= NB) ? BW'(r_rem - NB) : r_rem[BW-1:0];
        end
    end

    assign o_done   = r_done;
    assign o_bucket = r_bkt;

endmodule

@@ hw/rtl/hgia_checker.sv @@
`timescale 1ns / 1ps
`include "hash_group_id_assigner_defines.svh"
module hgia_checker import hgia_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tvalid,
    input logic                o_s_tready,
    input logic [S_DATA_W-1:0] i_s_tdata,
    input logic                i_s_tlast,
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [M_DATA_W-1:0] o_m_tdata,
    input logic                o_m_tlast,
    input logic                i_cfg_we,
    input logic [CFG_AW-1:0]   i_cfg_addr,
    input logic [CFG_DW-1:0]   i_cfg_wdata
);

    `HGIA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid, "output transaction dropped while stalled")

    `HGIA_ASSERT_NOW(a_ovf_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[59], o_m_tdata[58:0] == 59'd0, "dropped item carries nonzero fields")

    `HGIA_ASSERT_NOW(a_new_count, i_clk, i_rst_n, o_m_tvalid && !o_m_tdata[59] && o_m_tdata[12], o_m_tdata[58:46] == 13'd1, "new group with count other than one")

    `HGIA_ASSERT_NOW(a_old_count, i_clk, i_rst_n, o_m_tvalid && !o_m_tdata[59] && !o_m_tdata[12], o_m_tdata[58:46] > 13'd1, "existing group with count below two")

endmodule

bind hash_group_id_assigner hgia_checker u_hgia_checker (.*);
